### src/bapm_pkg.sv
package bapm_pkg;

    localparam int NUM_COLUMNS = 8;
    localparam int COLUMN_W    = 3;
    localparam int CHUNK_W     = 64;
    localparam int NUM_CHUNKS  = 4;
    localparam int ROW_W       = CHUNK_W * NUM_CHUNKS;
    localparam int CNT_W       = $clog2(CHUNK_W + 1);
    localparam int TOT_W       = $clog2(ROW_W + 1);
    localparam int DATA_W      = 32;
    localparam int SUM_W       = DATA_W + 2;

    // only columns reachable through the 3-bit index get storage
    localparam int STORE_DEPTH = (NUM_COLUMNS < (1 << COLUMN_W)) ? NUM_COLUMNS
                                                                 : (1 << COLUMN_W);
    localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sd2147483648);

    typedef enum logic
    {
        OP_LOAD    = 1'b0,
        OP_COMPUTE = 1'b1
    } opcode_t;

    typedef logic [CNT_W-1:0] chunk_cnt_t;

    // SWAR bit count of one 64-bit chunk
    function automatic chunk_cnt_t popcount64(input logic [CHUNK_W-1:0] x);
        logic [CHUNK_W-1:0] v;
        begin
            v = x - ((x >> 1) & 64'h5555_5555_5555_5555);
            v = (v & 64'h3333_3333_3333_3333) + ((v >> 2) & 64'h3333_3333_3333_3333);
            v = (v + (v >> 4)) & 64'h0f0f_0f0f_0f0f_0f0f;
            v = v + (v >> 8);
            v = v + (v >> 16);
            v = v + (v >> 32);
            return v[CNT_W-1:0];
        end
    endfunction

endpackage

### src/bapm_ram.sv
module bapm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/binary_and_popcount_mac.sv
// An accepted compute moves through s1, s2, s3 and the output register to out_valid.
// Throughput: one transaction per cycle unless stalled; loads and computes mix freely.
// An in-range load is written at its accept edge; a compute in the next cycle sees it.
// Output stall freezes the whole pipe: in_stall follows out_stall while a result waits.
// Reset (rst_n low, async) empties the pipe; the column store is undefined until loaded.
module binary_and_popcount_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              opcode,
    input  logic [bapm_pkg::COLUMN_W-1:0]     column,
    input  logic [bapm_pkg::CHUNK_W-1:0]      bits_chunk0,
    input  logic [bapm_pkg::CHUNK_W-1:0]      bits_chunk1,
    input  logic [bapm_pkg::CHUNK_W-1:0]      bits_chunk2,
    input  logic [bapm_pkg::CHUNK_W-1:0]      bits_chunk3,
    input  logic signed [bapm_pkg::DATA_W-1:0] accum_in,
    input  logic                              use_accum,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [bapm_pkg::DATA_W-1:0] dot_result,
    output logic [bapm_pkg::COLUMN_W-1:0]     result_column
);
    import bapm_pkg::*;

    logic                 en;
    logic                 accept;
    logic                 is_compute;
    logic                 in_range;
    logic [ROW_W-1:0]     row_in;
    logic [ROW_W-1:0]     store_rdata;
    logic [ROW_W-1:0]     masked;

    // stage 1: store read in flight
    logic                 s1_valid_reg;
    logic [COLUMN_W-1:0]  s1_col_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    logic signed [DATA_W-1:0] s1_accum_reg;
    logic                 s1_use_reg;
    logic                 s1_hit_reg;

    // stage 2: per-chunk counts
    logic                 s2_valid_reg;
    logic [COLUMN_W-1:0]  s2_col_reg;
    chunk_cnt_t           s2_cnt_reg [NUM_CHUNKS];
    chunk_cnt_t           s2_cnt_next [NUM_CHUNKS];
    logic signed [DATA_W-1:0] s2_accum_reg;
    logic                 s2_use_reg;

    // stage 3: row total
    logic                 s3_valid_reg;
    logic [COLUMN_W-1:0]  s3_col_reg;
    logic [TOT_W-1:0]     s3_total_reg;
    logic [TOT_W-1:0]     s3_total_next;
    logic signed [DATA_W-1:0] s3_accum_reg;
    logic                 s3_use_reg;

    // stage 4: output register
    logic                 out_valid_reg;
    logic signed [DATA_W-1:0] dot_result_reg;
    logic signed [DATA_W-1:0] dot_result_next;
    logic [COLUMN_W-1:0]  result_column_reg;
    logic signed [SUM_W-1:0] sum;

    assign en         = !(out_valid_reg && out_stall);
    assign in_stall   = !en;
    assign accept     = in_valid && en;
    assign is_compute = (opcode == OP_COMPUTE);
    assign in_range   = (32'(column) < 32'(NUM_COLUMNS));
    assign row_in     = {bits_chunk3, bits_chunk2, bits_chunk1, bits_chunk0};

    bapm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (accept && !is_compute && in_range),
        .waddr (column[STORE_AW-1:0]),
        .wdata (row_in),
        .re    (accept),
        .raddr (column[STORE_AW-1:0]),
        .rdata (store_rdata)
    );

    // out-of-range column reads as all zeros
    assign masked = s1_row_reg & (s1_hit_reg ? store_rdata : '0);

    always_comb
    begin
        for (int i = 0; i < NUM_CHUNKS; i++)
        begin
            s2_cnt_next[i] = popcount64(masked[i*CHUNK_W +: CHUNK_W]);
        end
    end

    always_comb
    begin
        s3_total_next = '0;
        for (int i = 0; i < NUM_CHUNKS; i++)
        begin
            s3_total_next = s3_total_next + TOT_W'(s2_cnt_reg[i]);
        end
    end

    always_comb
    begin
        sum = $signed({{(SUM_W-TOT_W){1'b0}}, s3_total_reg});
        if (s3_use_reg)
        begin
            sum = sum + SUM_W'(s3_accum_reg);
        end
        if (sum > SAT_MAX)
        begin
            dot_result_next = SAT_MAX[DATA_W-1:0];
        end
        else if (sum < SAT_MIN)
        begin
            dot_result_next = SAT_MIN[DATA_W-1:0];
        end
        else
        begin
            dot_result_next = sum[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= accept && is_compute;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_col_reg   <= column;
            s1_row_reg   <= row_in;
            s1_accum_reg <= accum_in;
            s1_use_reg   <= use_accum;
            s1_hit_reg   <= in_range;

            s2_col_reg   <= s1_col_reg;
            for (int i = 0; i < NUM_CHUNKS; i++)
            begin
                s2_cnt_reg[i] <= s2_cnt_next[i];
            end
            s2_accum_reg <= s1_accum_reg;
            s2_use_reg   <= s1_use_reg;

            s3_col_reg   <= s2_col_reg;
            s3_total_reg <= s3_total_next;
            s3_accum_reg <= s2_accum_reg;
            s3_use_reg   <= s2_use_reg;

            dot_result_reg    <= dot_result_next;
            result_column_reg <= s3_col_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign dot_result    = dot_result_reg;
    assign result_column = result_column_reg;

endmodule
